// File: rtl/sac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg: shared types, tables and functions of the simplified AES cipher
// The nibble S-boxes, the GF(16) arithmetic and the key expansion live here.
// ----------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

	localparam int unsigned BlockW = 16;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned NibW   = 4;

	typedef logic [BlockW-1:0] block_t;
	typedef logic [ByteW-1:0]  byte_t;
	typedef logic [NibW-1:0]   nib_t;

	// What a request asks of the datapath.
	typedef enum logic [0:0] {
		ACT_ENCRYPT = 1'b0,
		ACT_DECRYPT = 1'b1
	} action_t;

	// The three round keys, derived once per key write.
	typedef struct packed {
		block_t k0;
		block_t k1;
		block_t k2;
	} round_keys_t;

	localparam byte_t RCON_ONE = 8'h80;
	localparam byte_t RCON_TWO = 8'h30;

	localparam nib_t MIX_ENC_DIAG = 4'h1;
	localparam nib_t MIX_ENC_OFF  = 4'h4;
	localparam nib_t MIX_DEC_DIAG = 4'h9;
	localparam nib_t MIX_DEC_OFF  = 4'h2;

	localparam nib_t FWD_BOX [16] = '{
		4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
		4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
	};
	localparam nib_t INV_BOX [16] = '{
		4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
		4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
	};

	// Product in GF(16) modulo x^4+x+1. With one constant operand it folds to XORs.
	function automatic nib_t gf_mul(input nib_t a, input nib_t b);
		logic [NibW:0] aa;
		nib_t          acc;
		aa  = {1'b0, a};
		acc = '0;
		for (int i = 0; i < NibW; i++) begin
			if (b[i]) begin
				acc = acc ^ aa[NibW-1:0];
			end
			aa = {aa[NibW-1:0], 1'b0};
			if (aa[NibW]) begin
				aa = aa ^ 5'h13;
			end
		end
		return acc;
	endfunction

	function automatic block_t sub_fwd(input block_t s);
		block_t r;
		for (int i = 0; i < 4; i++) begin
			r[i*NibW +: NibW] = FWD_BOX[s[i*NibW +: NibW]];
		end
		return r;
	endfunction

	function automatic block_t sub_inv(input block_t s);
		block_t r;
		for (int i = 0; i < 4; i++) begin
			r[i*NibW +: NibW] = INV_BOX[s[i*NibW +: NibW]];
		end
		return r;
	endfunction

	// Swaps the second and the fourth nibble; it is its own inverse.
	function automatic block_t shift_rows(input block_t s);
		return {s[15:12], s[3:0], s[7:4], s[11:8]};
	endfunction

	function automatic block_t mix(input block_t s, input nib_t diag, input nib_t off);
		nib_t n0, n1, n2, n3;
		n0 = s[15:12];
		n1 = s[11:8];
		n2 = s[7:4];
		n3 = s[3:0];
		return {gf_mul(diag, n0) ^ gf_mul(off, n1),
			gf_mul(off, n0) ^ gf_mul(diag, n1),
			gf_mul(diag, n2) ^ gf_mul(off, n3),
			gf_mul(off, n2) ^ gf_mul(diag, n3)};
	endfunction

	// Rotate the two nibbles of a byte and pass each through the S-box.
	function automatic byte_t sub_rot(input byte_t w);
		return {FWD_BOX[w[3:0]], FWD_BOX[w[7:4]]};
	endfunction

	function automatic round_keys_t expand_key(input block_t key);
		byte_t       w0, w1, w2, w3, w4, w5;
		round_keys_t rk;
		w0 = key[15:8];
		w1 = key[7:0];
		w2 = w0 ^ RCON_ONE ^ sub_rot(w1);
		w3 = w2 ^ w1;
		w4 = w2 ^ RCON_TWO ^ sub_rot(w3);
		w5 = w4 ^ w3;
		rk.k0 = key;
		rk.k1 = {w2, w3};
		rk.k2 = {w4, w5};
		return rk;
	endfunction

endpackage

`default_nettype wire

// File: rtl/sac_key_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_key_sched: cipher key register and round key store
// Expands the key when it is written and holds all three round keys.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_key_sched (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_wr_en,
	input  wire sac_pkg::block_t     cfg_wr_data,
	output sac_pkg::round_keys_t     round_keys
);

	sac_pkg::round_keys_t keys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= sac_pkg::expand_key(sac_pkg::block_t'(0));
		end else if (cfg_wr_en) begin
			keys_q <= sac_pkg::expand_key(cfg_wr_data);
		end
	end

	assign round_keys = keys_q;

endmodule

`default_nettype wire

// File: rtl/sac_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_datapath: both cipher rounds in one pass of logic
// Encrypts or decrypts one block with the given round keys.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_datapath (
	input  wire sac_pkg::action_t     action,
	input  wire sac_pkg::block_t      data_block,
	input  wire sac_pkg::round_keys_t round_keys,
	output sac_pkg::block_t           result_block
);

	sac_pkg::block_t enc_a, enc_b, enc_c;
	sac_pkg::block_t dec_a, dec_b, dec_c;

	always_comb begin
		enc_a = sac_pkg::shift_rows(sac_pkg::sub_fwd(data_block ^ round_keys.k0));
		enc_b = sac_pkg::mix(enc_a, sac_pkg::MIX_ENC_DIAG, sac_pkg::MIX_ENC_OFF)
			^ round_keys.k1;
		enc_c = sac_pkg::shift_rows(sac_pkg::sub_fwd(enc_b)) ^ round_keys.k2;

		dec_a = sac_pkg::sub_inv(sac_pkg::shift_rows(data_block ^ round_keys.k2))
			^ round_keys.k1;
		dec_b = sac_pkg::mix(dec_a, sac_pkg::MIX_DEC_DIAG, sac_pkg::MIX_DEC_OFF);
		dec_c = sac_pkg::sub_inv(sac_pkg::shift_rows(dec_b)) ^ round_keys.k0;

		unique case (action)
			sac_pkg::ACT_ENCRYPT: result_block = enc_c;
			sac_pkg::ACT_DECRYPT: result_block = dec_c;
			default:              result_block = enc_c;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/simplified_aes_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplified_aes_cipher: two-round simplified AES on 16-bit blocks
// Streams blocks in and out; each request is encrypted or decrypted with
// round keys derived from a 16-bit cipher key.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Contents
//  s_*       in         s_tvalid / s_tready   tuser: action, tdata: data_block
//  m_*       out        m_tvalid / m_tready   tdata: result_block
//  cfg_*     in         cfg_wr_en             cfg_wr_data: cipher_key
//
// A request passes through the input register and then the result register,
// with both cipher rounds computed in the logic between.
// A new request can be taken every cycle while m_tready is high; throughput is then one block per cycle.
// The key register resets to zero and its round keys to the expansion of zero.
// The input register keeps accepting while a result waits to be taken, as long
// as it is itself empty.
// A key write is expanded in the cycle it arrives and is used from the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module simplified_aes_cipher (
	input  wire                   clk,
	input  wire                   arst_n,
	// Configuration: cipher key.
	input  wire                   cfg_wr_en,
	input  wire [15:0]            cfg_wr_data,
	// Input stream.
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire [15:0]            s_tdata,   // [15:0] data_block
	input  wire [0:0]             s_tuser,   // [0] action
	// Output stream.
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [15:0]           m_tdata    // [15:0] result_block
);

	sac_pkg::round_keys_t round_keys;

	// Input register stage.
	logic             valid_s1;
	sac_pkg::action_t action_s1;
	sac_pkg::block_t  data_s1;

	// Result register.
	logic             out_valid_q;
	sac_pkg::block_t  result_q;

	sac_pkg::block_t  result_d;
	logic             out_free;
	logic             advance;
	logic             in_accept;

	sac_key_sched u_key_sched (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.round_keys  (round_keys)
	);

	sac_datapath u_datapath (
		.action       (action_s1),
		.data_block   (data_s1),
		.round_keys   (round_keys),
		.result_block (result_d)
	);

	// The result register can take a new block when it is empty or being drained.
	assign out_free  = !out_valid_q || m_tready;
	assign advance   = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign in_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1 <= sac_pkg::action_t'(s_tuser[0]);
			data_s1   <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

`ifndef ASSERT_OFF
	// An empty input register must always be able to take a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input refused while the input register is empty");

	// A request moved on appears as a valid result in the next cycle.
	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("request moved on but no result is shown");

	// A held request is never overwritten while the result side is stalled.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("input accepted over a stalled request");

	// The stored round keys always match the expansion of the stored key.
	a_keys_match: assert property (@(posedge clk) disable iff (!arst_n)
		round_keys == sac_pkg::expand_key(round_keys.k0))
		else $error("round keys do not match the cipher key");
`endif

endmodule

`default_nettype wire

// File: tb/tb_simplified_aes_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simplified_aes_cipher: self-checking bench for the simplified AES cipher
// Feeds encrypt and decrypt requests under a sequence of cipher keys, with
// random gaps on the input and random back-pressure on the output, and
// compares every result block against the bench's cipher model or a known vector.
// ----------------------------------------------------------------------------

module tb_simplified_aes_cipher;

	localparam int unsigned RESET_CYCLES = 9;
	localparam int unsigned MAX_GAP      = 6;
	localparam int unsigned IDLE_LIMIT   = 1000;
	localparam int unsigned END_SETTLE   = 8;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned KEY_PHASES   = 10;
	localparam int unsigned PHASE_BLOCKS = 103;

	// Key schedule and mixing constants of the cipher.
	localparam logic [7:0] ROUND_CONST_1 = 8'h80;
	localparam logic [7:0] ROUND_CONST_2 = 8'h30;
	localparam logic [3:0] ENC_MIX_DIAG  = 4'h1;
	localparam logic [3:0] ENC_MIX_OFF   = 4'h4;
	localparam logic [3:0] DEC_MIX_DIAG  = 4'h9;
	localparam logic [3:0] DEC_MIX_OFF   = 4'h2;

	localparam logic [3:0] SBOX_FWD [16] = '{
		4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
		4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
	};
	localparam logic [3:0] SBOX_INV [16] = '{
		4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
		4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
	};

	// One directed request: the key it runs under, the request itself and,
	// where the answer is a published test vector, that answer.
	typedef struct packed {
		sac_pkg::block_t  key;
		sac_pkg::action_t act;
		sac_pkg::block_t  data;
		logic             known;
		sac_pkg::block_t  known_result;
	} directed_row_t;

	localparam int unsigned DIRECTED_ROWS = 21;

	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Key left at its reset value: extremes and alternating patterns.
		'{16'h0000, sac_pkg::ACT_ENCRYPT, 16'h0000, 1'b0, 16'h0000},
		'{16'h0000, sac_pkg::ACT_ENCRYPT, 16'hFFFF, 1'b0, 16'h0000},
		'{16'h0000, sac_pkg::ACT_DECRYPT, 16'h0000, 1'b0, 16'h0000},
		'{16'h0000, sac_pkg::ACT_DECRYPT, 16'hFFFF, 1'b0, 16'h0000},
		'{16'h0000, sac_pkg::ACT_ENCRYPT, 16'h5555, 1'b0, 16'h0000},
		'{16'h0000, sac_pkg::ACT_DECRYPT, 16'hAAAA, 1'b0, 16'h0000},
		// The textbook key: its vector both ways, then three more blocks.
		'{16'h4AF5, sac_pkg::ACT_ENCRYPT, 16'hD728, 1'b1, 16'h24EC},
		'{16'h4AF5, sac_pkg::ACT_DECRYPT, 16'h24EC, 1'b1, 16'hD728},
		'{16'h4AF5, sac_pkg::ACT_ENCRYPT, 16'h0001, 1'b0, 16'h0000},
		'{16'h4AF5, sac_pkg::ACT_DECRYPT, 16'h8000, 1'b0, 16'h0000},
		'{16'h4AF5, sac_pkg::ACT_ENCRYPT, 16'h1234, 1'b0, 16'h0000},
		// All-ones key.
		'{16'hFFFF, sac_pkg::ACT_ENCRYPT, 16'h0000, 1'b0, 16'h0000},
		'{16'hFFFF, sac_pkg::ACT_ENCRYPT, 16'hFFFF, 1'b0, 16'h0000},
		'{16'hFFFF, sac_pkg::ACT_DECRYPT, 16'h0000, 1'b0, 16'h0000},
		'{16'hFFFF, sac_pkg::ACT_DECRYPT, 16'hFFFF, 1'b0, 16'h0000},
		'{16'hFFFF, sac_pkg::ACT_ENCRYPT, 16'hF0F0, 1'b0, 16'h0000},
		'{16'hFFFF, sac_pkg::ACT_DECRYPT, 16'h0F0F, 1'b0, 16'h0000},
		// Zero key written explicitly, then another common example key.
		'{16'h0000, sac_pkg::ACT_ENCRYPT, 16'h8421, 1'b0, 16'h0000},
		'{16'h0000, sac_pkg::ACT_DECRYPT, 16'h1248, 1'b0, 16'h0000},
		'{16'hA73B, sac_pkg::ACT_ENCRYPT, 16'h6F6B, 1'b0, 16'h0000},
		'{16'hA73B, sac_pkg::ACT_DECRYPT, 16'h0738, 1'b0, 16'h0000}
	};

	// A request in flight and the block it should come back as.
	typedef struct {
		sac_pkg::action_t act;
		sac_pkg::block_t  data;
		sac_pkg::block_t  result;
	} pending_block_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = 16'h0000;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata     = 16'h0000;   // [15:0] data_block
	logic [0:0]  s_tuser     = 1'b0;       // [0] action
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [15:0] m_tdata;                  // [15:0] result_block

	pending_block_t   expected_blocks [$];
	sac_pkg::block_t  cipher_key = 16'h0000;
	int unsigned      fault_count = 0;
	logic             no_idle = 1'b0;
	sac_pkg::action_t last_act = sac_pkg::ACT_ENCRYPT;
	sac_pkg::block_t  last_result = 16'h0000;

	simplified_aes_cipher u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always #2 clk = ~clk;

	// Product in GF(16) modulo x^4+x+1, by repeated doubling of the first operand.
	function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
		logic [3:0] prod;
		logic [3:0] dbl;
		prod = 4'h0;
		dbl  = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) begin
				prod = prod ^ dbl;
			end
			dbl = {dbl[2:0], 1'b0} ^ (dbl[3] ? 4'h3 : 4'h0);
		end
		return prod;
	endfunction

	function automatic sac_pkg::block_t nibble_sub(input sac_pkg::block_t s, input logic inverse);
		sac_pkg::block_t r;
		for (int i = 0; i < 4; i++) begin
			r[4*i +: 4] = inverse ? SBOX_INV[s[4*i +: 4]] : SBOX_FWD[s[4*i +: 4]];
		end
		return r;
	endfunction

	// The second and fourth nibbles trade places; applying it twice restores the block.
	function automatic sac_pkg::block_t swap_rows(input sac_pkg::block_t s);
		return {s[15:12], s[3:0], s[7:4], s[11:8]};
	endfunction

	function automatic sac_pkg::block_t mix_cols(input sac_pkg::block_t s,
			input logic [3:0] diag, input logic [3:0] off);
		return {gf16_mul(diag, s[15:12]) ^ gf16_mul(off, s[11:8]),
			gf16_mul(off, s[15:12]) ^ gf16_mul(diag, s[11:8]),
			gf16_mul(diag, s[7:4]) ^ gf16_mul(off, s[3:0]),
			gf16_mul(off, s[7:4]) ^ gf16_mul(diag, s[3:0])};
	endfunction

	// Nibble rotation of a key byte followed by substitution.
	function automatic logic [7:0] rot_sub(input logic [7:0] w);
		return {SBOX_FWD[w[3:0]], SBOX_FWD[w[7:4]]};
	endfunction

	function automatic sac_pkg::block_t cipher_block(input sac_pkg::block_t key,
			input sac_pkg::action_t act, input sac_pkg::block_t data);
		logic [7:0]      w2, w3, w4, w5;
		sac_pkg::block_t k1, k2, s;
		w2 = key[15:8] ^ ROUND_CONST_1 ^ rot_sub(key[7:0]);
		w3 = w2 ^ key[7:0];
		w4 = w2 ^ ROUND_CONST_2 ^ rot_sub(w3);
		w5 = w4 ^ w3;
		k1 = {w2, w3};
		k2 = {w4, w5};
		if (act == sac_pkg::ACT_ENCRYPT) begin
			s = swap_rows(nibble_sub(data ^ key, 1'b0));
			s = mix_cols(s, ENC_MIX_DIAG, ENC_MIX_OFF) ^ k1;
			s = swap_rows(nibble_sub(s, 1'b0)) ^ k2;
		end else begin
			s = nibble_sub(swap_rows(data ^ k2), 1'b1) ^ k1;
			s = mix_cols(s, DEC_MIX_DIAG, DEC_MIX_OFF);
			s = nibble_sub(swap_rows(s), 1'b1) ^ key;
		end
		return s;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endtask

	// Lowers the request line and holds until every outstanding result is back.
	// Always lets the clock run before returning, so tvalid never sees two updates at once.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (expected_blocks.size() != 0);
	endtask

	task automatic load_key(input sac_pkg::block_t key);
		wait_for_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= key;
		@(negedge clk);
		cfg_wr_en  <= 1'b0;
		cipher_key = key;
	endtask

	// Presents one request, after a random gap unless no_idle is set, and records its
	// expected result at the edge where it is taken. Entered and left at a falling edge.
	task automatic send_block(input sac_pkg::action_t act, input sac_pkg::block_t data,
			input logic known, input sac_pkg::block_t known_result);
		int unsigned    gap;
		pending_block_t item;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= act;
		do @(posedge clk); while (s_tready !== 1'b1);
		item.act    = act;
		item.data   = data;
		item.result = known ? known_result : cipher_block(cipher_key, act, data);
		expected_blocks.push_back(item);
		last_act    = act;
		last_result = item.result;
		@(negedge clk);
	endtask

	initial begin : stimulus
		sac_pkg::block_t  key;
		sac_pkg::block_t  data;
		sac_pkg::action_t act;
		int unsigned      pick;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows; the key changes only between drained phases.
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (DIRECTED[r].key != cipher_key) begin
				load_key(DIRECTED[r].key);
			end
			send_block(DIRECTED[r].act, DIRECTED[r].data, DIRECTED[r].known,
				DIRECTED[r].known_result);
		end

		// Random phases, one key each; the first two use the extreme keys.
		for (int p = 0; p < KEY_PHASES; p++) begin
			if (p == 0) begin
				key = 16'hFFFF;
			end else if (p == 1) begin
				key = 16'h0000;
			end else begin
				key = 16'($urandom_range(0, 16'hFFFF));
			end
			load_key(key);
			no_idle = (p == 2) || ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_BLOCKS; i++) begin
				// Once, mid-phase, let the pipeline run completely dry.
				if (p == 4 && i == PHASE_BLOCKS / 2) begin
					wait_for_results();
				end
				pick = $urandom_range(0, 15);
				act  = sac_pkg::action_t'($urandom_range(0, 1));
				if (pick == 0) begin
					data = 16'h0000;
				end else if (pick == 1) begin
					data = 16'hFFFF;
				end else if (pick <= 3) begin
					// Feed the last answer back the other way: a round trip.
					data = last_result;
					act  = (last_act == sac_pkg::ACT_ENCRYPT) ?
						sac_pkg::ACT_DECRYPT : sac_pkg::ACT_ENCRYPT;
				end else begin
					data = 16'($urandom_range(0, 16'hFFFF));
				end
				send_block(act, data, 1'b0, 16'h0000);
			end
		end

		no_idle = 1'b0;
		wait_for_results();
		repeat (END_SETTLE) @(posedge clk);
		if (fault_count == 0 && expected_blocks.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Result side: random back-pressure per block, checked in order of arrival.
	initial begin : result_sink
		int unsigned    stall;
		pending_block_t item;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			if (expected_blocks.size() == 0) begin
				note_fault($sformatf("result %h with no request outstanding", m_tdata));
			end else begin
				item = expected_blocks.pop_front();
				if (m_tdata !== item.result) begin
					note_fault($sformatf("%s of %h: expected %h, got %h",
						item.act.name(), item.data, item.result, m_tdata));
				end
			end
		end
	end

	// Ends the run if neither side moves a block for too long.
	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
rtl/sac_pkg.sv
rtl/sac_key_sched.sv
rtl/sac_datapath.sv
rtl/simplified_aes_cipher.sv
tb/tb_simplified_aes_cipher.sv
